### src/assert_macros.svh
// Assertion macros shared by the point-to-segment distance RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, sampled on clk, off while in reset.
`define PSD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication into the next cycle, sampled on clk, off while in reset.
`define PSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/psd_pkg.sv
// Types and constants shared by the point-to-segment distance pipeline.
package psd_pkg;

  localparam int DIFF_W = 33;  // coordinate difference
  localparam int PROD_W = 66;  // product of two differences
  localparam int LEN2_W = 67;  // squared segment length
  localparam int DOT_W  = 68;  // signed dot product
  localparam int Q_W    = 32;  // quotient register
  localparam int T_W    = 33;  // projection parameter
  localparam int OFF_W  = 68;  // rounded offset
  localparam int D_W    = 34;  // distance component
  localparam int SQ_W   = 72;  // squared distance component
  localparam int RAD_W  = 68;  // square root radicand
  localparam int ROOT_W = 34;  // square root result
  localparam int REM_W  = 36;  // square root remainder

  // Selection of the projection parameter
  localparam logic [1:0] T_ZERO = 2'd0;
  localparam logic [1:0] T_ONE  = 2'd1;
  localparam logic [1:0] T_DIV  = 2'd2;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
  } in_t;

  typedef struct packed {
    logic [32:0] distance;
    logic [32:0] param;
    logic        degenerate;
  } out_t;

  typedef struct packed {
    logic [2:0][DIFF_W-1:0] ap;
    logic [2:0][DIFF_W-1:0] abs_ab;
    logic [2:0]             ab_neg;
    logic [LEN2_W-1:0]      len2;
    logic [LEN2_W-1:0]      rem;
    logic [1:0]             tsel;
    logic                   degenerate;
  } front_t;

  typedef struct packed {
    front_t         f;
    logic [Q_W-1:0] q;
  } div_t;

  typedef struct packed {
    logic [2:0][DIFF_W-1:0] ap;
    logic [2:0][DIFF_W-1:0] abs_ab;
    logic [2:0]             ab_neg;
    logic [T_W-1:0]         t;
    logic                   degenerate;
  } close_t;

  typedef struct packed {
    logic [RAD_W-1:0] rad;
    logic [T_W-1:0]   t;
    logic             degenerate;
  } root_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [T_W-1:0]    t;
    logic              degenerate;
  } sqrt_t;

endpackage

### src/psd_front.sv
// Front pipeline: differences, products, sums and classification of t.
`include "assert_macros.svh"
module psd_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_v,
  input  psd_pkg::in_t     in_data,
  output logic             out_v,
  output psd_pkg::front_t  out_data
);
  import psd_pkg::*;

  logic signed [31:0]       p [3];
  logic signed [31:0]       a [3];
  logic signed [31:0]       b [3];

  logic                     v1_r, v2_r, v3_r, v4_r;
  logic signed [DIFF_W-1:0] ab1_r [3];
  logic signed [DIFF_W-1:0] ap1_r [3];
  logic signed [DIFF_W-1:0] ab2_r [3];
  logic signed [DIFF_W-1:0] ap2_r [3];
  logic signed [PROD_W-1:0] sq2_r [3];
  logic signed [PROD_W-1:0] dp2_r [3];
  logic signed [DIFF_W-1:0] ab3_r [3];
  logic signed [DIFF_W-1:0] ap3_r [3];
  logic [LEN2_W-1:0]        len2_r;
  logic signed [DOT_W-1:0]  dot_r;
  logic [LEN2_W-1:0]        len2_nxt;
  logic signed [DOT_W-1:0]  dot_nxt;
  front_t                   fr_r;
  front_t                   fr_nxt;

  assign p[0] = in_data.point_x;
  assign p[1] = in_data.point_y;
  assign p[2] = in_data.point_z;
  assign a[0] = in_data.start_x;
  assign a[1] = in_data.start_y;
  assign a[2] = in_data.start_z;
  assign b[0] = in_data.end_x;
  assign b[1] = in_data.end_y;
  assign b[2] = in_data.end_z;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Stage 1: coordinate differences
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        ab1_r[k] <= DIFF_W'(b[k]) - DIFF_W'(a[k]);
        ap1_r[k] <= DIFF_W'(p[k]) - DIFF_W'(a[k]);
      end
    end
  end

  // Stage 2: squared length terms and dot product terms
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        sq2_r[k] <= ab1_r[k] * ab1_r[k];
        dp2_r[k] <= ap1_r[k] * ab1_r[k];
        ab2_r[k] <= ab1_r[k];
        ap2_r[k] <= ap1_r[k];
      end
    end
  end

  // Stage 3: sum the terms
  always_comb begin
    len2_nxt = LEN2_W'(sq2_r[0]) + LEN2_W'(sq2_r[1]) + LEN2_W'(sq2_r[2]);
    dot_nxt  = DOT_W'(dp2_r[0]) + DOT_W'(dp2_r[1]) + DOT_W'(dp2_r[2]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      len2_r <= len2_nxt;
      dot_r  <= dot_nxt;
      for (int k = 0; k < 3; k++) begin
        ab3_r[k] <= ab2_r[k];
        ap3_r[k] <= ap2_r[k];
      end
    end
  end

  // Stage 4: clamp decision, divider seed and direction magnitudes
  always_comb begin
    fr_nxt            = '0;
    fr_nxt.len2       = len2_r;
    fr_nxt.rem        = dot_r[LEN2_W-1:0];
    fr_nxt.degenerate = (len2_r == '0);
    for (int k = 0; k < 3; k++) begin
      fr_nxt.ap[k]     = ap3_r[k];
      fr_nxt.ab_neg[k] = ab3_r[k][DIFF_W-1];
      fr_nxt.abs_ab[k] = ab3_r[k][DIFF_W-1] ? DIFF_W'(-ab3_r[k]) : DIFF_W'(ab3_r[k]);
    end
    if (dot_r[DOT_W-1] || dot_r == '0) begin
      fr_nxt.tsel = T_ZERO;
    end else if (dot_r >= $signed({1'b0, len2_r})) begin
      fr_nxt.tsel = T_ONE;
    end else begin
      fr_nxt.tsel = T_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fr_r <= fr_nxt;
    end
  end

  assign out_v    = v4_r;
  assign out_data = fr_r;

  `PSD_ASSERT_IMP(a_deg_zero_t, out_v && out_data.degenerate, out_data.tsel == T_ZERO, "degenerate segment must clamp t to zero")

endmodule

### src/psd_div.sv
// Pipelined restoring divider for the projection parameter, one quotient bit per stage.
`include "assert_macros.svh"
module psd_div #(
  parameter int PARAM_FRAC_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_v,
  input  psd_pkg::front_t  in_data,
  output logic             out_v,
  output psd_pkg::close_t  out_data
);
  import psd_pkg::*;

  localparam int NSTG = PARAM_FRAC_BITS;

  div_t stg_r [1:NSTG];
  logic v_r   [1:NSTG];
  div_t seed;
  div_t last;

  // One restoring step: shift the remainder, subtract when it fits
  function automatic div_t div_step(input div_t x);
    div_t              y;
    logic [LEN2_W:0]   rr;
    y  = x;
    rr = {x.f.rem, 1'b0};
    if (rr >= {1'b0, x.f.len2}) begin
      y.f.rem = LEN2_W'(rr - {1'b0, x.f.len2});
      y.q     = {x.q[Q_W-2:0], 1'b1};
    end else begin
      y.f.rem = LEN2_W'(rr);
      y.q     = {x.q[Q_W-2:0], 1'b0};
    end
    return y;
  endfunction

  assign seed.f = in_data;
  assign seed.q = '0;

  for (genvar i = 1; i <= NSTG; i++) begin : g_stage
    if (i == 1) begin : g_first
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[i] <= 1'b0;
        end else if (adv) begin
          v_r[i] <= in_v;
        end
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          stg_r[i] <= div_step(seed);
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[i] <= 1'b0;
        end else if (adv) begin
          v_r[i] <= v_r[i-1];
        end
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          stg_r[i] <= div_step(stg_r[i-1]);
        end
      end
    end
  end

  // Select zero, one or the quotient
  assign last = stg_r[NSTG];
  always_comb begin
    out_data.ap         = last.f.ap;
    out_data.abs_ab     = last.f.abs_ab;
    out_data.ab_neg     = last.f.ab_neg;
    out_data.degenerate = last.f.degenerate;
    case (last.f.tsel)
      T_ZERO:  out_data.t = '0;
      T_ONE:   out_data.t = T_W'(1) << PARAM_FRAC_BITS;
      default: out_data.t = T_W'(last.q);
    endcase
  end

  assign out_v = v_r[NSTG];

  `PSD_ASSERT_IMP(a_t_range, out_v, out_data.t <= (T_W'(1) << PARAM_FRAC_BITS), "projection parameter above one")

endmodule

### src/psd_close.sv
// Closest point offsets, distance components and squared distance.
module psd_close #(
  parameter int PARAM_FRAC_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_v,
  input  psd_pkg::close_t  in_data,
  output logic             out_v,
  output psd_pkg::root_t   out_data
);
  import psd_pkg::*;

  localparam logic signed [OFF_W-1:0] RND = OFF_W'(1) << (PARAM_FRAC_BITS - 1);

  logic                     v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [PROD_W-1:0]        prod1_r [3];
  logic [2:0]               neg1_r;
  logic [2:0][DIFF_W-1:0]   ap1_r, ap2_r;
  logic [T_W-1:0]           t1_r, t2_r, t3_r, t4_r, t5_r;
  logic                     dg1_r, dg2_r, dg3_r, dg4_r, dg5_r;
  logic signed [OFF_W-1:0]  rs2_r [3];
  logic signed [D_W-1:0]    d3_r [3];
  logic signed [SQ_W-1:0]   sq4_r [3];
  logic [RAD_W-1:0]         rad5_r;
  logic signed [OFF_W-1:0]  offv [3];
  logic signed [OFF_W-1:0]  ap_ext [3];
  logic signed [SQ_W-1:0]   sum_nxt;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // Stage 1: t times direction magnitude
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        prod1_r[k] <= PROD_W'(in_data.t) * PROD_W'(in_data.abs_ab[k]);
      end
      neg1_r <= in_data.ab_neg;
      ap1_r  <= in_data.ap;
      t1_r   <= in_data.t;
      dg1_r  <= in_data.degenerate;
    end
  end

  // Stage 2: apply sign and add one half
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        rs2_r[k] <= neg1_r[k] ? RND - $signed({2'b00, prod1_r[k]})
                              : RND + $signed({2'b00, prod1_r[k]});
      end
      ap2_r <= ap1_r;
      t2_r  <= t1_r;
      dg2_r <= dg1_r;
    end
  end

  // Stage 3: floor to an integer offset, subtract from P-A
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      offv[k]   = rs2_r[k] >>> PARAM_FRAC_BITS;
      ap_ext[k] = OFF_W'($signed(ap2_r[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        d3_r[k] <= D_W'(ap_ext[k] - offv[k]);
      end
      t3_r  <= t2_r;
      dg3_r <= dg2_r;
    end
  end

  // Stage 4: square each component
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        sq4_r[k] <= d3_r[k] * d3_r[k];
      end
      t4_r  <= t3_r;
      dg4_r <= dg3_r;
    end
  end

  // Stage 5: squared distance
  assign sum_nxt = sq4_r[0] + sq4_r[1] + sq4_r[2];

  always_ff @(posedge clk) begin
    if (adv) begin
      rad5_r <= sum_nxt[RAD_W-1:0];
      t5_r   <= t4_r;
      dg5_r  <= dg4_r;
    end
  end

  assign out_v               = v5_r;
  assign out_data.rad        = rad5_r;
  assign out_data.t          = t5_r;
  assign out_data.degenerate = dg5_r;

endmodule

### src/psd_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module psd_sqrt (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_v,
  input  psd_pkg::root_t  in_data,
  output logic            out_v,
  output psd_pkg::out_t   out_data
);
  import psd_pkg::*;

  sqrt_t stg_r [1:ROOT_W];
  logic  v_r   [1:ROOT_W];
  sqrt_t seed;

  // Bring down two radicand bits, try root*4+1
  function automatic sqrt_t sqrt_step(input sqrt_t x);
    sqrt_t            y;
    logic [REM_W+1:0] rr;
    logic [REM_W+1:0] trial;
    y     = x;
    rr    = {x.rem, x.rad[RAD_W-1 -: 2]};
    trial = {2'b00, x.root, 2'b01};
    if (rr >= trial) begin
      y.rem  = REM_W'(rr - trial);
      y.root = {x.root[ROOT_W-2:0], 1'b1};
    end else begin
      y.rem  = REM_W'(rr);
      y.root = {x.root[ROOT_W-2:0], 1'b0};
    end
    y.rad = {x.rad[RAD_W-3:0], 2'b00};
    return y;
  endfunction

  assign seed.rad        = in_data.rad;
  assign seed.rem        = '0;
  assign seed.root       = '0;
  assign seed.t          = in_data.t;
  assign seed.degenerate = in_data.degenerate;

  for (genvar i = 1; i <= ROOT_W; i++) begin : g_stage
    if (i == 1) begin : g_first
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[i] <= 1'b0;
        end else if (adv) begin
          v_r[i] <= in_v;
        end
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          stg_r[i] <= sqrt_step(seed);
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[i] <= 1'b0;
        end else if (adv) begin
          v_r[i] <= v_r[i-1];
        end
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          stg_r[i] <= sqrt_step(stg_r[i-1]);
        end
      end
    end
  end

  assign out_v               = v_r[ROOT_W];
  assign out_data.distance   = stg_r[ROOT_W].root[32:0];
  assign out_data.param      = stg_r[ROOT_W].t;
  assign out_data.degenerate = stg_r[ROOT_W].degenerate;

endmodule

### src/point_segment_distance_3d.sv
// Top level: point to segment distance pipeline with output buffer.
//
//   Channel   Ports                          Moves
//   input     in_valid, in_stall, in_data    point, segment start and end
//   output    out_valid, out_stall, out_data distance, param, degenerate
//
// One item per cycle while in_stall is low. Stages in order: 4 front stages,
// one divider stage per bit of t, 5 closest-point stages, 34 square root
// stages and one output register.
// Reset clears all valid bits and the output buffer; no clearing pass.
// The two-entry output buffer takes results while out_stall is high; the whole
// pipeline holds only when both entries are full, which raises in_stall.
`include "assert_macros.svh"
module point_segment_distance_3d #(
  parameter int PARAM_FRAC_BITS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  psd_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output psd_pkg::out_t  out_data
);
  import psd_pkg::*;

  logic   adv;
  logic   fr_v, dv_v, cl_v, sq_v;
  front_t fr_data;
  close_t dv_data;
  root_t  cl_data;
  out_t   sq_data;
  logic   push, pop;
  logic [1:0] cnt_r, cnt_nxt;
  out_t   head_r, head_nxt;
  out_t   skid_r, skid_nxt;

  // Hold the pipeline only when the output buffer is full
  assign adv      = (cnt_r != 2'd2);
  assign in_stall = !adv;

  psd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_v     (in_valid),
    .in_data  (in_data),
    .out_v    (fr_v),
    .out_data (fr_data)
  );

  psd_div #(.PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_v     (fr_v),
    .in_data  (fr_data),
    .out_v    (dv_v),
    .out_data (dv_data)
  );

  psd_close #(.PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_close (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_v     (dv_v),
    .in_data  (dv_data),
    .out_v    (cl_v),
    .out_data (cl_data)
  );

  psd_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_v     (cl_v),
    .in_data  (cl_data),
    .out_v    (sq_v),
    .out_data (sq_data)
  );

  // Output buffer: head register plus one skid entry
  assign push = adv && sq_v;
  assign pop  = (cnt_r != 2'd0) && !out_stall;

  always_comb begin
    cnt_nxt  = cnt_r;
    head_nxt = head_r;
    skid_nxt = skid_r;
    case (cnt_r)
      2'd0: begin
        if (push) begin
          head_nxt = sq_data;
          cnt_nxt  = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          head_nxt = sq_data;
        end else if (push) begin
          skid_nxt = sq_data;
          cnt_nxt  = 2'd2;
        end else if (pop) begin
          cnt_nxt  = 2'd0;
        end
      end
      2'd2: begin
        if (pop) begin
          head_nxt = skid_r;
          cnt_nxt  = 2'd1;
        end
      end
      default: cnt_nxt = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = head_r;

  `PSD_ASSERT_IMP(a_stall_full, in_stall, out_valid, "input stalled with an empty output buffer")
  `PSD_ASSERT_NEXT(a_full_holds, (cnt_r == 2'd2) && out_stall, in_stall, "full buffer released without a transfer")
  `PSD_ASSERT_IMP(a_deg_param, out_valid && out_data.degenerate, out_data.param == '0, "degenerate result with nonzero param")

endmodule
